// ===== design/dependency_parse_state_engine_defines.svh =====
// Assertion macros used by the checker file dps_checker.sv.
`ifndef DEPENDENCY_PARSE_STATE_ENGINE_DEFINES_SVH
`define DEPENDENCY_PARSE_STATE_ENGINE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define DPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define DPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== design/dps_pkg.sv =====
package dps_pkg;
  localparam int MaxTokens = 128;
  localparam int MaxLabels = 1024;
  localparam int TokW = 8;
  localparam int LabW = 11;
  localparam int IdxW = 7;
  localparam int SpW = 8;

  typedef enum logic [3:0] {
    CMD_START = 4'd0, CMD_ADVANCE = 4'd1, CMD_PUSH = 4'd2, CMD_POP = 4'd3,
    CMD_ADD_ARC = 4'd4, CMD_INPUT_AT = 4'd5, CMD_STACK_AT = 4'd6, CMD_HEAD = 4'd7,
    CMD_LABEL = 4'd8, CMD_PARENT = 4'd9, CMD_LEFTMOST = 4'd10, CMD_RIGHTMOST = 4'd11,
    CMD_LEFT_SIB = 4'd12, CMD_RIGHT_SIB = 4'd13
  } cmd_t;

  localparam logic [LabW-1:0] NoneValue = 11'h7FE;
  localparam logic [TokW-1:0] RootTok = 8'hFF;

  // Datapath operations requested by the controller.
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_CLEAR, OP_READ, OP_STEP, OP_WRITE, OP_STACK_RD
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [IdxW-1:0]     addr;
  } dp_cmd_t;

  typedef struct packed {
    logic [TokW-1:0] head;
    logic [LabW-1:0] label;
    logic [TokW-1:0] stack_data;
  } dp_stat_t;
endpackage

// ===== design/dps_datapath.sv =====
module dps_datapath (
  input  logic                          clk,
  input  dps_pkg::dp_cmd_t              cmd,
  input  logic [dps_pkg::TokW-1:0]      wr_head,
  input  logic [dps_pkg::LabW-1:0]      wr_label,
  input  logic                          stk_we,
  input  logic [dps_pkg::SpW-1:0]       stk_addr,
  input  logic [dps_pkg::TokW-1:0]      stk_wdata,
  output dps_pkg::dp_stat_t             stat
);
  import dps_pkg::*;

  logic [TokW-1:0] head_mem [MaxTokens];
  logic [LabW-1:0] label_mem [MaxTokens];
  logic [TokW-1:0] stack_mem [MaxTokens+1];
  logic [TokW-1:0] head_rd_r;
  logic [LabW-1:0] label_rd_r;
  logic [TokW-1:0] stack_rd_r;

  assign stat = '{head: head_rd_r, label: label_rd_r, stack_data: stack_rd_r};

  // Tables: read each cycle, write on write/clear; clearing is a controller-driven sweep.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_WRITE || cmd.op == OP_CLEAR) begin
      head_mem[cmd.addr]  <= wr_head;
      label_mem[cmd.addr] <= wr_label;
    end
    head_rd_r  <= head_mem[cmd.addr];
    label_rd_r <= label_mem[cmd.addr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_addr] <= stk_wdata;
    end
    stack_rd_r <= stack_mem[stk_addr];
  end
endmodule

// ===== design/dps_ctrl.sv =====
module dps_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [3:0]                    i_cmd,
  input  logic [dps_pkg::TokW-1:0]      i_tok,
  input  logic [dps_pkg::TokW-1:0]      i_hd,
  input  logic [dps_pkg::LabW-1:0]      i_lab,
  input  logic [dps_pkg::TokW-1:0]      i_off,
  input  logic                          cfg_we,
  input  logic                          cfg_idx,
  input  logic [dps_pkg::LabW-1:0]      cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dps_pkg::LabW-1:0]      o_res,
  output logic [dps_pkg::SpW-1:0]       o_sp,
  output logic [dps_pkg::SpW-1:0]       o_cur,
  output logic                          o_done,
  output logic                          o_err,
  output dps_pkg::dp_cmd_t              dcmd,
  output logic [dps_pkg::TokW-1:0]      wr_head,
  output logic [dps_pkg::LabW-1:0]      wr_label,
  output logic                          stk_we,
  output logic [dps_pkg::SpW-1:0]       stk_addr,
  output logic [dps_pkg::TokW-1:0]      stk_wdata,
  input  dps_pkg::dp_stat_t             stat
);
  import dps_pkg::*;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DISPATCH, S_CLEAR, S_STK_WAIT, S_STK_DONE,
    S_RD_WAIT, S_RD_DONE, S_SCAN_WAIT, S_SCAN, S_OUT
  } state_t;

  state_t state_r;
  logic [7:0] count_r;
  logic [LabW-1:0] root_lab_r;
  logic [SpW-1:0] sp_r, cur_r;
  logic [3:0] cmd_r;
  logic signed [9:0] tok_r, hd_r, off_r;
  logic [LabW-1:0] lab_r;
  logic [LabW-1:0] res_r;
  logic err_r;
  logic [IdxW:0] clr_r;
  // Scan state: current token, scan position, remaining count, target head.
  logic signed [9:0] cur_tok_r, pos_r, h_r;
  logic signed [9:0] k_r;
  logic phase_r;

  logic signed [9:0] n_s;
  assign n_s = (count_r > 8'd128) ? 10'sd128 : $signed({2'b00, count_r});

  logic signed [9:0] head_rd;
  assign head_rd = $signed({{2{stat.head[TokW-1]}}, stat.head});

  logic tok_ok;
  assign tok_ok = (tok_r >= -10'sd1) && (tok_r < n_s);

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign o_res = res_r;
  assign o_sp = sp_r;
  assign o_cur = cur_r;
  assign o_done = ($signed({2'b00, cur_r}) == n_s);
  assign o_err = err_r;

  // Next scan address (signed; its low 7 bits address the tables; only used when in range).
  logic signed [9:0] addr_s;

  always_comb begin
    dcmd = '{op: OP_NONE, addr: '0};
    wr_head = RootTok;
    // The pass after reset always fills labels with the reset root label.
    wr_label = (state_r == S_INIT) ? '1 : root_lab_r;
    stk_we = 1'b0;
    stk_addr = sp_r;
    stk_wdata = tok_r[TokW-1:0];
    addr_s = pos_r;
    case (state_r)
      S_INIT, S_CLEAR: begin
        dcmd.op = OP_CLEAR;
        dcmd.addr = clr_r[IdxW-1:0];
      end
      S_DISPATCH: begin
        dcmd.addr = tok_r[IdxW-1:0];
        if (cmd_r == CMD_ADD_ARC) begin
          wr_head = hd_r[TokW-1:0];
          wr_label = lab_r;
        end
        if (cmd_r == CMD_POP) stk_addr = sp_r - 8'd1;
        if (cmd_r == CMD_STACK_AT) stk_addr = sp_r - 8'd1 - off_r[SpW-1:0];
        if (cmd_r == CMD_ADD_ARC && tok_r >= 0 && tok_r < n_s && hd_r >= -10'sd1 &&
            hd_r < n_s && lab_r[LabW-1] == 1'b0 || cmd_r == CMD_ADD_ARC && lab_r == '1 &&
            tok_r >= 0 && tok_r < n_s && hd_r >= -10'sd1 && hd_r < n_s)
          dcmd.op = OP_WRITE;
        if (cmd_r == CMD_PUSH) stk_we = tok_ok && ({2'b00, sp_r} < n_s + 10'sd1) && !err_r;
      end
      S_STK_WAIT: begin
        stk_addr = (cmd_r == CMD_POP) ? sp_r : sp_r - 8'd1 - off_r[SpW-1:0];
      end
      S_RD_WAIT, S_SCAN_WAIT, S_SCAN: begin
        dcmd.op = OP_READ;
        dcmd.addr = addr_s[IdxW-1:0];
      end
      default: ;
    endcase
  end

  function automatic logic signed [9:0] tbl_head(input logic signed [9:0] t,
                                                 input logic signed [9:0] rd);
    tbl_head = (t < 0) ? -10'sd1 : rd;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      count_r <= '0;
      root_lab_r <= '1;
      sp_r <= '0;
      cur_r <= '0;
      clr_r <= '0;
      err_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx) root_lab_r <= cfg_data;
        else count_r <= cfg_data[7:0];
      end
      case (state_r)
        S_INIT, S_CLEAR: begin
          clr_r <= clr_r + (IdxW+1)'(1);
          if (clr_r == (IdxW+1)'(MaxTokens - 1)) state_r <= (state_r == S_INIT) ? S_IDLE : S_OUT;
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd_r <= i_cmd;
            tok_r <= 10'($signed(i_tok));
            hd_r <= 10'($signed(i_hd));
            lab_r <= i_lab;
            off_r <= 10'($signed(i_off));
            res_r <= NoneValue;
            err_r <= 1'b0;
            state_r <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          state_r <= S_OUT;
          case (cmd_r)
            CMD_START: begin
              sp_r <= '0; cur_r <= '0; clr_r <= '0; state_r <= S_CLEAR;
            end
            CMD_ADVANCE: begin
              if ($signed({2'b00, cur_r}) >= n_s) err_r <= 1'b1;
              else cur_r <= cur_r + 8'd1;
            end
            CMD_PUSH: begin
              if (!tok_ok || ({2'b00, sp_r} >= n_s + 10'sd1)) err_r <= 1'b1;
              else sp_r <= sp_r + 8'd1;
            end
            CMD_POP: begin
              if (sp_r == 0) err_r <= 1'b1;
              else begin
                sp_r <= sp_r - 8'd1;
                state_r <= S_STK_WAIT;
              end
            end
            CMD_ADD_ARC: begin
              if (!(tok_r >= 0 && tok_r < n_s && hd_r >= -10'sd1 && hd_r < n_s &&
                    (lab_r[LabW-1] == 1'b0 || lab_r == '1))) err_r <= 1'b1;
            end
            CMD_INPUT_AT: begin
              if ($signed({2'b00, cur_r}) + off_r >= -10'sd1 &&
                  $signed({2'b00, cur_r}) + off_r < n_s)
                res_r <= LabW'($signed({2'b00, cur_r}) + off_r);
            end
            CMD_STACK_AT: begin
              if (off_r >= 0 && $signed({2'b00, sp_r}) - 10'sd1 - off_r >= 0)
                state_r <= S_STK_WAIT;
            end
            CMD_HEAD, CMD_LABEL, CMD_PARENT, CMD_LEFTMOST, CMD_RIGHTMOST,
            CMD_LEFT_SIB, CMD_RIGHT_SIB: begin
              if (!tok_ok) err_r <= 1'b1;
              else begin
                cur_tok_r <= tok_r;
                k_r <= off_r;
                phase_r <= 1'b0;
                pos_r <= tok_r;
                case (cmd_r)
                  CMD_HEAD: begin
                    if (tok_r < 0) res_r <= '1; else state_r <= S_RD_WAIT;
                  end
                  CMD_LABEL: begin
                    if (tok_r < 0) res_r <= root_lab_r; else state_r <= S_RD_WAIT;
                  end
                  default: begin
                    res_r <= LabW'(tok_r);
                    if (off_r > 0) begin
                      if ((cmd_r == CMD_LEFT_SIB || cmd_r == CMD_RIGHT_SIB) && tok_r < 0)
                        res_r <= NoneValue;
                      else begin
                        state_r <= S_RD_WAIT;
                        // Siblings first read the head of the token itself.
                        if (cmd_r == CMD_LEFTMOST) pos_r <= -10'sd1;
                        if (cmd_r == CMD_RIGHTMOST) pos_r <= n_s - 10'sd1;
                      end
                    end
                  end
                endcase
              end
            end
            default: err_r <= 1'b1;
          endcase
        end
        S_STK_WAIT: state_r <= S_STK_DONE;
        S_STK_DONE: begin
          res_r <= LabW'($signed(stat.stack_data));
          state_r <= S_OUT;
        end
        S_RD_WAIT: state_r <= S_RD_DONE;
        S_RD_DONE: begin
          // One table read has landed for pos_r.
          case (cmd_r)
            CMD_HEAD: begin
              res_r <= LabW'(head_rd); state_r <= S_OUT;
            end
            CMD_LABEL: begin
              res_r <= stat.label; state_r <= S_OUT;
            end
            CMD_PARENT: begin
              cur_tok_r <= tbl_head(pos_r, head_rd);
              res_r <= LabW'(tbl_head(pos_r, head_rd));
              k_r <= k_r - 10'sd1;
              pos_r <= tbl_head(pos_r, head_rd);
              if (k_r == 10'sd1 || tbl_head(pos_r, head_rd) < 0) begin
                // The root stays the root under further steps.
                state_r <= S_OUT;
              end else state_r <= S_RD_WAIT;
            end
            CMD_LEFTMOST, CMD_RIGHTMOST: begin
              if (pos_r == cur_tok_r) begin
                res_r <= NoneValue; state_r <= S_OUT;
              end else if (tbl_head(pos_r, head_rd) == cur_tok_r) begin
                res_r <= LabW'(pos_r);
                cur_tok_r <= pos_r;
                k_r <= k_r - 10'sd1;
                if (k_r == 10'sd1) state_r <= S_OUT;
                else begin
                  pos_r <= (cmd_r == CMD_LEFTMOST) ? -10'sd1 : n_s - 10'sd1;
                  state_r <= S_RD_WAIT;
                end
              end else begin
                pos_r <= (cmd_r == CMD_LEFTMOST) ? pos_r + 10'sd1 : pos_r - 10'sd1;
                state_r <= S_RD_WAIT;
              end
            end
            default: begin
              // Sibling walk: phase 0 captures the head of the token.
              if (!phase_r) begin
                h_r <= head_rd;
                phase_r <= 1'b1;
              end else if (tbl_head(pos_r, head_rd) == h_r) begin
                if (k_r == 10'sd1) begin
                  res_r <= LabW'(pos_r); state_r <= S_OUT;
                end
                k_r <= k_r - 10'sd1;
              end
              if (phase_r && tbl_head(pos_r, head_rd) == h_r && k_r == 10'sd1) begin
              end else if (cmd_r == CMD_LEFT_SIB) begin
                if (pos_r - 10'sd1 <= -10'sd1) begin
                  res_r <= NoneValue; state_r <= S_OUT;
                end else begin
                  pos_r <= pos_r - 10'sd1; state_r <= S_RD_WAIT;
                end
              end else begin
                if (pos_r + 10'sd1 >= n_s) begin
                  res_r <= NoneValue; state_r <= S_OUT;
                end else begin
                  pos_r <= pos_r + 10'sd1; state_r <= S_RD_WAIT;
                end
              end
            end
          endcase
        end
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== design/dependency_parse_state_engine.sv =====
// Parse state engine: every beat on the input returns exactly one result beat.
// A start sweeps the 128-entry head and label tables at one entry per cycle. Tree
// queries walk the head table through a single read port, one visited entry at a
// time. After reset the tables are cleared in a pass before the first input beat
// is taken; configuration writes are taken at any time.
module dependency_parse_state_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // command[3:0], token_index[11:4], head_index[19:12], arc_label[30:20],
  // offset_or_count[38:31], zero fill
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // result_value[10:0], stack_depth[18:11], cursor_position[26:19],
  // input_done[27], error_flag[28], zero fill
  output logic [31:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data
);
  import dps_pkg::*;

  dp_cmd_t dcmd;
  dp_stat_t stat;
  logic [TokW-1:0] wr_head, stk_wdata;
  logic [LabW-1:0] wr_label, o_res;
  logic stk_we, o_done, o_err;
  logic [SpW-1:0] stk_addr, o_sp, o_cur;

  assign cfg_ready = 1'b1;
  assign out_tdata = {3'b000, o_err, o_done, o_cur, o_sp, o_res};

  dps_ctrl u_ctrl (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .i_cmd(in_tdata[3:0]), .i_tok(in_tdata[11:4]), .i_hd(in_tdata[19:12]),
    .i_lab(in_tdata[30:20]), .i_off(in_tdata[38:31]),
    .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_data,
    .out_valid(out_tvalid), .out_ready(out_tready),
    .o_res, .o_sp, .o_cur, .o_done, .o_err,
    .dcmd, .wr_head, .wr_label, .stk_we, .stk_addr, .stk_wdata, .stat
  );

  dps_datapath u_dp (
    .clk, .cmd(dcmd), .wr_head, .wr_label, .stk_we, .stk_addr, .stk_wdata, .stat
  );
endmodule

// ===== design/dps_checker.sv =====
`include "dependency_parse_state_engine_defines.svh"
module dps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);
  `DPS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `DPS_ASSERT_IMP(a_no_overlap, clk, rst_n, out_tvalid, !in_tready)
  `DPS_ASSERT_IMP(a_depth_bound, clk, rst_n, out_tvalid, out_tdata[18:11] <= 8'd129)
  `DPS_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_tvalid && in_tready, !in_tready)
endmodule

bind dependency_parse_state_engine dps_checker u_chk (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata
);
